FILE: rtl/core/ppl_pkg.sv
package ppl_pkg;

  // Bytes per line buffer; a buffer holds at most LINE_BYTES-1 bytes.
  localparam int LINE_BYTES = 64;
  localparam int COUNT_BITS = $clog2(LINE_BYTES);
  localparam int ADDR_BITS  = $clog2(2 * LINE_BYTES);
  localparam int BYTE_BITS  = 8;
  localparam int LEN_BITS   = 6;
  localparam int CFG_BITS   = 2;

  localparam logic [COUNT_BITS-1:0] FILL_LIMIT = COUNT_BITS'(LINE_BYTES - 1);
  localparam logic [ADDR_BITS-1:0]  BUF1_BASE  = ADDR_BITS'(LINE_BYTES);

  // Input operation codes.
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_TX_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_BITS-1:0] CFG_TERM_FIRST  = CFG_BITS'(0);
  localparam logic [CFG_BITS-1:0] CFG_TERM_SECOND = CFG_BITS'(1);

  localparam logic [BYTE_BITS-1:0] TERM_FIRST_RST  = 8'd13;
  localparam logic [BYTE_BITS-1:0] TERM_SECOND_RST = 8'd10;

  // Result of one beat, minus the byte that comes back from the store.
  typedef struct packed {
    logic                tx_valid;
    logic                tx_finished;
    logic                line_done;
    logic                done_buffer;
    logic [LEN_BITS-1:0] done_length;
    logic                overflow_drop;
  } res_t;

endpackage

FILE: rtl/core/ppl_ram.sv
module ppl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/ppl_ctrl.sv
module ppl_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                op,
  input  logic [ppl_pkg::BYTE_BITS-1:0]       data_byte,
  input  logic                                cfg_we,
  input  logic [ppl_pkg::CFG_BITS-1:0]        cfg_index,
  input  logic [ppl_pkg::BYTE_BITS-1:0]       cfg_data,
  output logic                                ram_we,
  output logic                                ram_re,
  output logic [ppl_pkg::ADDR_BITS-1:0]       ram_addr,
  output logic [ppl_pkg::BYTE_BITS-1:0]       ram_wdata,
  output ppl_pkg::res_t                       res
);

  logic [ppl_pkg::BYTE_BITS-1:0]  term_first;
  logic [ppl_pkg::BYTE_BITS-1:0]  term_second;
  logic [ppl_pkg::COUNT_BITS-1:0] fill_count [2];
  logic                           active_buffer;
  logic [ppl_pkg::COUNT_BITS-1:0] send_index;
  logic                           sending;

  logic                           sel_buf;
  logic [ppl_pkg::COUNT_BITS-1:0] sel_count;
  logic [ppl_pkg::COUNT_BITS-1:0] sel_index;
  logic                           is_term;
  logic                           do_store;
  logic                           do_drop;
  logic                           do_send;
  logic                           do_finish;

  // Receive works on the active buffer, transmit on the other one.
  assign sel_buf   = active_buffer ^ op;
  assign sel_count = fill_count[sel_buf];
  assign is_term   = (data_byte == term_first) || (data_byte == term_second);

  assign do_store  = (op == ppl_pkg::OP_RX_BYTE) && !is_term &&
                     (sel_count < ppl_pkg::FILL_LIMIT);
  assign do_drop   = (op == ppl_pkg::OP_RX_BYTE) && !is_term &&
                     (sel_count >= ppl_pkg::FILL_LIMIT);
  assign do_send   = (op == ppl_pkg::OP_TX_TICK) && sending && (send_index < sel_count);
  assign do_finish = (op == ppl_pkg::OP_TX_TICK) && sending && (send_index >= sel_count);

  assign sel_index = (op == ppl_pkg::OP_RX_BYTE) ? sel_count : send_index;
  assign ram_addr  = sel_buf ? (ppl_pkg::BUF1_BASE + ppl_pkg::ADDR_BITS'(sel_index))
                             : ppl_pkg::ADDR_BITS'(sel_index);
  assign ram_wdata = data_byte;
  assign ram_we    = accept && do_store;
  assign ram_re    = accept && do_send;

  always_comb begin
    res               = '0;
    res.tx_valid      = do_send;
    res.tx_finished   = do_finish;
    res.overflow_drop = do_drop;
    if ((op == ppl_pkg::OP_RX_BYTE) && is_term) begin
      res.line_done   = 1'b1;
      res.done_buffer = active_buffer;
      res.done_length = ppl_pkg::LEN_BITS'(sel_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_first    <= ppl_pkg::TERM_FIRST_RST;
      term_second   <= ppl_pkg::TERM_SECOND_RST;
      fill_count[0] <= '0;
      fill_count[1] <= '0;
      active_buffer <= 1'b0;
      send_index    <= '0;
      sending       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ppl_pkg::CFG_TERM_FIRST:  term_first  <= cfg_data;
          ppl_pkg::CFG_TERM_SECOND: term_second <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if ((op == ppl_pkg::OP_RX_BYTE) && is_term) begin
          active_buffer        <= ~active_buffer;
          fill_count[~sel_buf] <= '0;
          send_index           <= '0;
          sending              <= 1'b1;
        end else if (do_store) begin
          fill_count[sel_buf] <= sel_count + 1'b1;
        end else if (do_send) begin
          send_index <= send_index + 1'b1;
        end else if (do_finish) begin
          sending             <= 1'b0;
          fill_count[sel_buf] <= '0;
          send_index          <= '0;
        end
      end
    end
  end

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (send_index == '0))
    else $error("send index nonzero while not draining");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_count[0] <= ppl_pkg::FILL_LIMIT) && (fill_count[1] <= ppl_pkg::FILL_LIMIT))
    else $error("fill count beyond buffer capacity");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == ppl_pkg::OP_TX_TICK) && !sending) |-> (res == '0) && !ram_we)
    else $error("idle tick produced a result or a write");

endmodule

FILE: rtl/core/ppl_out.sv
module ppl_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  ppl_pkg::res_t                 res,
  input  logic [ppl_pkg::BYTE_BITS-1:0] ram_rdata,
  output logic                          item_stall,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          tx_valid,
  output logic [ppl_pkg::BYTE_BITS-1:0] tx_byte,
  output logic                          tx_finished,
  output logic                          line_done,
  output logic                          done_buffer,
  output logic [ppl_pkg::LEN_BITS-1:0]  done_length,
  output logic                          overflow_drop
);

  logic          pend_valid;
  ppl_pkg::res_t pend;
  logic          pend_move;

  // Pending stage holds the beat's fields while the store's registered read completes.
  assign pend_move  = pend_valid && (!result_valid || !result_stall);
  assign item_stall = pend_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= res;
    end
    if (pend_move) begin
      tx_valid      <= pend.tx_valid;
      tx_byte       <= pend.tx_valid ? ram_rdata : '0;
      tx_finished   <= pend.tx_finished;
      line_done     <= pend.line_done;
      done_buffer   <= pend.done_buffer;
      done_length   <= pend.done_length;
      overflow_drop <= pend.overflow_drop;
    end
  end

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({tx_valid, tx_finished, line_done, overflow_drop}))
    else $error("result carries more than one kind of event");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !tx_valid) |-> (tx_byte == '0))
    else $error("tx byte nonzero without tx valid");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_move) |-> !accept)
    else $error("beat accepted over a held pending entry");

endmodule

FILE: rtl/core/ping_pong_line_buffer.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    op, data_byte
// result    out        result_valid / result_stall tx_valid, tx_byte, tx_finished,
//                                                 line_done, done_buffer,
//                                                 done_length, overflow_drop
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One beat per cycle sustained while the result side does not stall; each item
// yields exactly one result (store's registered read, then the output register).
// rst is synchronous: terminators return to CR/LF, both counts and the drain
// state clear. The line store is not cleared; only written entries are read.
// A stalled result holds the output register; the item side stalls only once
// the pending stage behind it is also full. cfg_ready is always high.
module ping_pong_line_buffer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          op,
  input  logic [ppl_pkg::BYTE_BITS-1:0] data_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          tx_valid,
  output logic [ppl_pkg::BYTE_BITS-1:0] tx_byte,
  output logic                          tx_finished,
  output logic                          line_done,
  output logic                          done_buffer,
  output logic [ppl_pkg::LEN_BITS-1:0]  done_length,
  output logic                          overflow_drop,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppl_pkg::CFG_BITS-1:0]  cfg_index,
  input  logic [ppl_pkg::BYTE_BITS-1:0] cfg_data
);

  logic                          accept;
  logic                          ram_we;
  logic                          ram_re;
  logic [ppl_pkg::ADDR_BITS-1:0] ram_addr;
  logic [ppl_pkg::BYTE_BITS-1:0] ram_wdata;
  logic [ppl_pkg::BYTE_BITS-1:0] ram_rdata;
  ppl_pkg::res_t                 res;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && !item_stall;

  // Counts, buffer select, drain pointer and terminator registers.
  ppl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .data_byte (data_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .res       (res)
  );

  // Both line buffers share one store; buffer 1 sits at LINE_BYTES upward.
  // Receive writes the active half while transmit reads the other, and a beat
  // is either one or the other, so one port serves both.
  ppl_ram #(
    .WIDTH (ppl_pkg::BYTE_BITS),
    .DEPTH (2 * ppl_pkg::LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Hold the result fields until the read data lands, then register the beat.
  ppl_out u_out (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .res           (res),
    .ram_rdata     (ram_rdata),
    .item_stall    (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .tx_finished   (tx_finished),
    .line_done     (line_done),
    .done_buffer   (done_buffer),
    .done_length   (done_length),
    .overflow_drop (overflow_drop)
  );

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the two-stage result path empty out before touching config.
  localparam int SETTLE_CYCLES = 4;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 300;

  // One result beat, field for field as the block presents it.
  typedef struct packed {
    logic                          tx_valid;
    logic [ppl_pkg::BYTE_BITS-1:0] tx_byte;
    logic                          tx_finished;
    logic                          line_done;
    logic                          done_buffer;
    logic [ppl_pkg::LEN_BITS-1:0]  done_length;
    logic                          overflow_drop;
  } beat_t;

  // Directed row: the beat to send, how many times, and an optional literal
  // result that replaces the predicted one.
  typedef struct packed {
    logic                          op;
    logic [ppl_pkg::BYTE_BITS-1:0] data;
    logic [6:0]                    reps;
    logic                          pinned;
    beat_t                         want;
  } line_case_t;

  localparam beat_t QUIET = '0;

  localparam int NUM_CASES = 18;
  localparam line_case_t LINE_CASES [NUM_CASES] = '{
    // tick straight after reset: nothing armed, all-zero result
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd1,  1'b1, QUIET},
    // byte extremes into buffer 0
    '{ppl_pkg::OP_RX_BYTE, 8'h00, 7'd1,  1'b0, QUIET},
    '{ppl_pkg::OP_RX_BYTE, 8'hFF, 7'd1,  1'b0, QUIET},
    // carriage return closes a two-byte line in buffer 0
    '{ppl_pkg::OP_RX_BYTE, 8'h0D, 7'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 6'd2, 1'b0}},
    // drain the first byte; data_byte on a tick is don't-care
    '{ppl_pkg::OP_TX_TICK, 8'hFF, 7'd1,  1'b0, QUIET},
    // receive into buffer 1 while buffer 0 drains
    '{ppl_pkg::OP_RX_BYTE, 8'h41, 7'd1,  1'b0, QUIET},
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd1,  1'b0, QUIET},
    // tick past the last byte reports the drain finished
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd1,  1'b0, QUIET},
    // tick while idle again
    '{ppl_pkg::OP_TX_TICK, 8'h5A, 7'd1,  1'b1, QUIET},
    // line feed closes buffer 1
    '{ppl_pkg::OP_RX_BYTE, 8'h0A, 7'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 6'd1, 1'b0}},
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd1,  1'b0, QUIET},
    // terminator mid-drain: empty line in buffer 0, drain restarts on it
    '{ppl_pkg::OP_RX_BYTE, 8'h0D, 7'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 6'd0, 1'b0}},
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd1,  1'b0, QUIET},
    // fill buffer 1 to capacity, then one byte too many is dropped
    '{ppl_pkg::OP_RX_BYTE, 8'h55, 7'd63, 1'b0, QUIET},
    '{ppl_pkg::OP_RX_BYTE, 8'hAA, 7'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 1'b1}},
    // full line reports the largest length
    '{ppl_pkg::OP_RX_BYTE, 8'h0A, 7'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 6'd63, 1'b0}},
    // drain all 63 bytes plus the finishing tick
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd64, 1'b0, QUIET},
    '{ppl_pkg::OP_TX_TICK, 8'h00, 7'd1,  1'b1, QUIET}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic                          op = ppl_pkg::OP_RX_BYTE;
  logic [ppl_pkg::BYTE_BITS-1:0] data_byte = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic                          tx_valid;
  logic [ppl_pkg::BYTE_BITS-1:0] tx_byte;
  logic                          tx_finished;
  logic                          line_done;
  logic                          done_buffer;
  logic [ppl_pkg::LEN_BITS-1:0]  done_length;
  logic                          overflow_drop;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ppl_pkg::CFG_BITS-1:0]  cfg_index = ppl_pkg::CFG_TERM_FIRST;
  logic [ppl_pkg::BYTE_BITS-1:0] cfg_data = '0;

  ping_pong_line_buffer u_top (
    .clk, .rst,
    .item_valid, .item_stall, .op, .data_byte,
    .result_valid, .result_stall,
    .tx_valid, .tx_byte, .tx_finished, .line_done, .done_buffer, .done_length,
    .overflow_drop,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // Shadow of the block: two line buffers, their fill counts, which one is
  // receiving, and where the drain of the other one stands.
  logic [ppl_pkg::BYTE_BITS-1:0] shadow_line [2][ppl_pkg::LINE_BYTES];
  int unsigned                   shadow_fill [2];
  logic                          rx_side;
  int unsigned                   drain_pos;
  logic                          draining;
  logic [ppl_pkg::BYTE_BITS-1:0] term_a;
  logic [ppl_pkg::BYTE_BITS-1:0] term_b;

  beat_t       line_results [$];  // expected result beats, oldest first
  int unsigned beats_sent;
  int unsigned mismatches;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_req = 1'b0;

  // Advance the shadow by one accepted beat and return the result it causes.
  function automatic beat_t predict_line_beat(input logic o,
                                              input logic [ppl_pkg::BYTE_BITS-1:0] b);
    beat_t r;
    logic  tx_side;
    r = '0;
    if (o == ppl_pkg::OP_RX_BYTE) begin
      if (b == term_a || b == term_b) begin
        // close the line, swap buffers and arm a fresh drain
        r.line_done   = 1'b1;
        r.done_buffer = rx_side;
        r.done_length = ppl_pkg::LEN_BITS'(shadow_fill[rx_side]);
        rx_side = ~rx_side;
        shadow_fill[rx_side] = 0;
        drain_pos = 0;
        draining  = 1'b1;
      end else if (shadow_fill[rx_side] < ppl_pkg::LINE_BYTES - 1) begin
        shadow_line[rx_side][shadow_fill[rx_side]] = b;
        shadow_fill[rx_side]++;
      end else begin
        // buffer full: drop the byte and flag it
        r.overflow_drop = 1'b1;
      end
    end else if (draining) begin
      tx_side = ~rx_side;
      if (drain_pos < shadow_fill[tx_side]) begin
        r.tx_valid = 1'b1;
        r.tx_byte  = shadow_line[tx_side][drain_pos];
        drain_pos++;
      end else begin
        r.tx_finished = 1'b1;
        draining = 1'b0;
        shadow_fill[tx_side] = 0;
        drain_pos = 0;
      end
    end
    return r;
  endfunction

  // Offer one beat, after a random idle gap, and hold it until accepted.
  task automatic send_line_beat(input logic o, input logic [ppl_pkg::BYTE_BITS-1:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    data_byte  <= b;
    do @(posedge clk); while (item_stall);
    line_results.push_back(predict_line_beat(o, b));
    beats_sent++;
  endtask

  // Drop valid and wait until every expected beat is back, then let the
  // pipeline settle.
  task automatic wait_for_quiet();
    item_valid <= 1'b0;
    while (line_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one terminator register with the block idle.
  task automatic set_terminator(input logic [ppl_pkg::CFG_BITS-1:0] idx,
                                input logic [ppl_pkg::BYTE_BITS-1:0] val);
    wait_for_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ppl_pkg::CFG_TERM_FIRST) term_a = val;
    else if (idx == ppl_pkg::CFG_TERM_SECOND) term_b = val;
  endtask

  // Random traffic: mostly well-formed lines (body, terminator, drain ticks)
  // with random content and lengths, some running into overflow, some drains
  // cut short by the next line; the rest is raw noise on both operations.
  task automatic run_line_traffic(input int unsigned count);
    int unsigned                   goal;
    int unsigned                   len;
    int unsigned                   ticks;
    logic [ppl_pkg::BYTE_BITS-1:0] b;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(55, 72) : $urandom_range(0, 12);
        repeat (len) begin
          do b = ppl_pkg::BYTE_BITS'($urandom); while (b == term_a || b == term_b);
          // sprinkle ticks into the body so drains overlap reception
          if ($urandom_range(9) == 0)
            send_line_beat(ppl_pkg::OP_TX_TICK, ppl_pkg::BYTE_BITS'($urandom));
          send_line_beat(ppl_pkg::OP_RX_BYTE, b);
        end
        send_line_beat(ppl_pkg::OP_RX_BYTE, ($urandom_range(1) != 0) ? term_a : term_b);
        ticks = ($urandom_range(3) == 0) ? $urandom_range(0, len)
                                         : len + 1 + $urandom_range(2);
        repeat (ticks) send_line_beat(ppl_pkg::OP_TX_TICK, ppl_pkg::BYTE_BITS'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          send_line_beat(1'($urandom_range(1)), ppl_pkg::BYTE_BITS'($urandom));
      end
    end
  endtask

  // Receiver: stall at random per cycle, or hold off for a long stretch on
  // request so the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      result_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Score every result beat against the oldest expectation.
  always @(posedge clk) begin : score_results
    beat_t got;
    beat_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {tx_valid, tx_byte, tx_finished, line_done, done_buffer, done_length,
             overflow_drop};
      if (line_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing pending: %p", $time, got);
      end else begin
        want = line_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch\n  expected %p\n  actual   %p", $time, want, got);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("ping_pong_line_buffer regression: fail");
    $finish;
  end

  initial begin
    // Shadow state matches the block after reset.
    foreach (shadow_line[s, i]) shadow_line[s][i] = '0;
    shadow_fill[0] = 0;
    shadow_fill[1] = 0;
    rx_side      = 1'b0;
    drain_pos    = 0;
    draining     = 1'b0;
    term_a       = ppl_pkg::TERM_FIRST_RST;
    term_b       = ppl_pkg::TERM_SECOND_RST;
    beats_sent   = 0;
    mismatches   = 0;

    // Phase 1: sender mostly busy, receiver stalls often.
    tx_idle_pct  = 6;
    rx_stall_pct = 57;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed lines with the reset terminators.
    foreach (LINE_CASES[k]) begin
      repeat (LINE_CASES[k].reps) begin
        send_line_beat(LINE_CASES[k].op, LINE_CASES[k].data);
        // pin the literal result where it is obvious by inspection
        if (LINE_CASES[k].pinned) line_results[line_results.size() - 1] = LINE_CASES[k].want;
      end
    end

    run_line_traffic(330);
    // Hold the receiver off while the sender keeps offering beats.
    hold_req = 1'b1;
    run_line_traffic(330);

    // Phase 2: terminators at the byte extremes; sender idles often, receiver
    // rarely stalls.
    set_terminator(ppl_pkg::CFG_TERM_FIRST, 8'h00);
    set_terminator(ppl_pkg::CFG_TERM_SECOND, 8'hFF);
    tx_idle_pct  = 57;
    rx_stall_pct = 6;
    run_line_traffic(330);
    // Pause the sender until every beat is back, then carry on.
    wait_for_quiet();
    run_line_traffic(330);

    // Phase 3: back-to-back beats with random terminators, switched halfway.
    set_terminator(ppl_pkg::CFG_TERM_FIRST, ppl_pkg::BYTE_BITS'($urandom));
    set_terminator(ppl_pkg::CFG_TERM_SECOND, ppl_pkg::BYTE_BITS'($urandom));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_line_traffic(350);
    set_terminator(ppl_pkg::CFG_TERM_SECOND, 8'hFF);
    set_terminator(ppl_pkg::CFG_TERM_FIRST, ppl_pkg::BYTE_BITS'($urandom));
    run_line_traffic(350);

    // Drain: wait for the tail, bounded, then a few spare cycles.
    item_valid <= 1'b0;
    for (int w = 0; w < 10000 && line_results.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (line_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d result beats never arrived", $time, line_results.size());
    end

    if (mismatches == 0)
      $display("ping_pong_line_buffer regression: pass");
    else
      $display("ping_pong_line_buffer regression: fail");
    $finish;
  end

endmodule

FILE: ping_pong_line_buffer.f
rtl/core/ppl_pkg.sv
rtl/core/ppl_ram.sv
rtl/core/ppl_ctrl.sv
rtl/core/ppl_out.sv
rtl/core/ping_pong_line_buffer.sv
verif/testbench.sv
